// ===== hdl/tcgr_pkg.sv =====
package tcgr_pkg;

	// font geometry
	localparam int GLYPH_COUNT        = 256;
	localparam int MAX_GLYPH_ROWS_DEF = 16;
	localparam int TAB_SPACES_DEF     = 4;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_FG_COLOR     = 3'd0,
		REG_CLEAR_COLOR  = 3'd1,
		REG_SCREEN_WIDTH = 3'd2,
		REG_GLYPH_HEIGHT = 3'd3,
		REG_ENABLED      = 3'd4
	} cfg_reg_t;

	// reset values of the registers
	localparam logic [31:0] FG_COLOR_RST     = 32'hffff_ffff;
	localparam logic [31:0] CLEAR_COLOR_RST  = 32'h0000_0000;
	localparam logic [12:0] SCREEN_WIDTH_RST = 13'd640;
	localparam logic [4:0]  GLYPH_HEIGHT_RST = 5'd16;

	// input actions
	typedef enum logic [1:0] {
		ACT_TEXT  = 2'd0,
		ACT_CELL  = 2'd1,
		ACT_PIXEL = 2'd2,
		ACT_FONT  = 2'd3
	} action_t;

	// control characters
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_VT    = 8'd11;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;

	localparam int GLYPH_WIDTH = 8;

endpackage

// ===== hdl/text_console_glyph_renderer.sv =====
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------------------
// in       | sink      | in_valid / in_ready   | action, byte_value, cell_col, cell_row,
//          |           |                       | pixel_x, pixel_y, glyph_code, glyph_row,
//          |           |                       | glyph_bits
// out      | source    | out_valid / out_ready | row_x, row_y, row_mask, pixel_color, last
// cfg      | sink      | cfg_write             | cfg_index, cfg_data
//
// cursor moves, font loads, control bytes without drawing and ignored bytes leave the block idle.
// a drawn glyph or a backspace gives h result beats, a tab TAB_SPACES * h, where h is the
// effective glyph height: one result beat per glyph row, with one font store read per drawn row.
// the font store is a single-port memory with registered read, read one row ahead.
// a stalled output holds the sequencer; the next item is taken once the last beat is loaded.
// reset clears the cursor, the registers and the control state; the font store is not cleared.
module text_console_glyph_renderer #(
	parameter int MAX_GLYPH_ROWS = tcgr_pkg::MAX_GLYPH_ROWS_DEF,
	parameter int TAB_SPACES     = tcgr_pkg::TAB_SPACES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  byte_value,
	input  logic [12:0] cell_col,
	input  logic [11:0] cell_row,
	input  logic [15:0] pixel_x,
	input  logic [15:0] pixel_y,
	input  logic [7:0]  glyph_code,
	input  logic [3:0]  glyph_row,
	input  logic [7:0]  glyph_bits,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] row_x,
	output logic [15:0] row_y,
	output logic [7:0]  row_mask,
	output logic [31:0] pixel_color,
	output logic        last
);
	import tcgr_pkg::*;

	localparam int DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
	localparam int TW    = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [31:0] fg_color_q;
	logic [31:0] clear_color_q;
	logic [12:0] screen_width_q;
	logic [4:0]  glyph_height_q;
	logic        enabled_q;

	// cursor and sequencer
	logic [15:0]   cursor_x_q;
	logic [15:0]   cursor_y_q;
	logic [7:0]    code_q;
	logic [RW-1:0] row_q;
	logic [TW-1:0] glyphs_left_q;
	logic          clear_q;

	// output register
	logic        out_valid_q;
	logic [15:0] row_x_q;
	logic [15:0] row_y_q;
	logic [7:0]  row_mask_q;
	logic [31:0] pixel_color_q;
	logic        last_q;

	// font store
	logic [7:0]    font_mem [DEPTH];
	logic [7:0]    rd_data_q;
	logic          rd_en;
	logic [7:0]    rd_code;
	logic [RW-1:0] rd_row;
	logic          wr_en;

	logic          accept;
	logic          out_free;
	logic [4:0]    eff_h;
	logic          row_last;
	logic [16:0]   y_row_sum;
	logic [15:0]   y_row;
	logic [16:0]   y_h_sum;
	logic [15:0]   y_plus_h;
	logic [16:0]   x_probe;
	logic [15:0]   adv_x;
	logic [15:0]   adv_y;
	logic [15:0]   bs_x0;
	logic [15:0]   bs_x;
	logic [15:0]   bs_y;
	logic [16:0]   cell_y_prod;
	logic [15:0]   cell_y;
	logic          is_draw;
	logic          is_tab;

	function automatic logic [AW-1:0] font_addr(input logic [7:0] code,
		input logic [RW-1:0] row);
		font_addr = AW'(code) * AW'(MAX_GLYPH_ROWS) + AW'(row);
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// effective glyph height, clamped to 1 .. MAX_GLYPH_ROWS
	always_comb begin
		if (glyph_height_q == 5'd0) begin
			eff_h = 5'd1;
		end else if ({1'b0, glyph_height_q} > 6'(MAX_GLYPH_ROWS)) begin
			eff_h = 5'(MAX_GLYPH_ROWS);
		end else begin
			eff_h = glyph_height_q;
		end
	end

	assign row_last = (5'(row_q) == eff_h - 5'd1);

	// saturated y sums
	assign y_row_sum = {1'b0, cursor_y_q} + 17'(row_q);
	assign y_row     = y_row_sum[16] ? 16'hffff : y_row_sum[15:0];
	assign y_h_sum   = {1'b0, cursor_y_q} + 17'(eff_h);
	assign y_plus_h  = y_h_sum[16] ? 16'hffff : y_h_sum[15:0];

	// cursor advance after a glyph, wrapping at the screen edge
	always_comb begin
		x_probe = {1'b0, cursor_x_q} + 17'(2 * GLYPH_WIDTH);
		if (x_probe > 17'(screen_width_q)) begin
			adv_x = '0;
			adv_y = y_plus_h;
		end else begin
			adv_x = cursor_x_q + 16'(GLYPH_WIDTH);
			adv_y = cursor_y_q;
		end
	end

	// backspace step with wrap to the previous line
	always_comb begin
		bs_x0 = cursor_x_q;
		bs_y  = cursor_y_q;
		bs_x  = cursor_x_q;
		if (cursor_x_q != 16'd0 || cursor_y_q != 16'd0) begin
			if (cursor_x_q == 16'd0) begin
				bs_x0 = 16'(screen_width_q);
				bs_y  = (cursor_y_q > 16'(eff_h)) ? cursor_y_q - 16'(eff_h) : 16'd0;
			end
			bs_x = (bs_x0 >= 16'(GLYPH_WIDTH)) ? bs_x0 - 16'(GLYPH_WIDTH) : 16'd0;
		end
	end

	// cell position to pixels
	assign cell_y_prod = 17'(cell_row) * 17'(eff_h);
	assign cell_y      = cell_y_prod[16] ? 16'hffff : cell_y_prod[15:0];

	// byte classification
	assign is_tab  = (byte_value == CH_TAB);
	assign is_draw = !(byte_value == CH_NUL || byte_value == CH_LF || byte_value == CH_CR ||
		byte_value == CH_VT || byte_value == CH_BS);

	// font store read address, one row ahead of the emitted beat
	always_comb begin
		rd_en   = 1'b0;
		rd_code = code_q;
		rd_row  = '0;
		if (state_q == ST_IDLE) begin
			rd_code = is_tab ? CH_SPACE : byte_value;
			rd_en   = accept && (action_t'(action) == ACT_TEXT) && enabled_q && is_draw;
		end else if (out_free && !clear_q) begin
			if (!row_last) begin
				rd_row = row_q + RW'(1);
				rd_en  = 1'b1;
			end else begin
				rd_en = (glyphs_left_q != '0);
			end
		end
	end

	assign wr_en = accept && (action_t'(action) == ACT_FONT) &&
		({1'b0, glyph_row} < 5'(MAX_GLYPH_ROWS));

	// font store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			font_mem[font_addr(glyph_code, RW'(glyph_row))] <= glyph_bits;
		end
		if (rd_en) begin
			rd_data_q <= font_mem[font_addr(rd_code, rd_row)];
		end
	end

	// sequencer, cursor, registers and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fg_color_q     <= FG_COLOR_RST;
			clear_color_q  <= CLEAR_COLOR_RST;
			screen_width_q <= SCREEN_WIDTH_RST;
			glyph_height_q <= GLYPH_HEIGHT_RST;
			enabled_q      <= 1'b0;
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			code_q         <= '0;
			row_q          <= '0;
			glyphs_left_q  <= '0;
			clear_q        <= 1'b0;
			out_valid_q    <= 1'b0;
			row_x_q        <= '0;
			row_y_q        <= '0;
			row_mask_q     <= '0;
			pixel_color_q  <= '0;
			last_q         <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_write) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_FG_COLOR:     fg_color_q     <= cfg_data;
					REG_CLEAR_COLOR:  clear_color_q  <= cfg_data;
					REG_SCREEN_WIDTH: screen_width_q <= cfg_data[12:0];
					REG_GLYPH_HEIGHT: glyph_height_q <= cfg_data[4:0];
					REG_ENABLED:      enabled_q      <= cfg_data[0];
					default: ;
				endcase
			end

			// output beat taken
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (action_t'(action))
							ACT_TEXT: begin
								if (enabled_q) begin
									unique case (byte_value)
										CH_NUL: ;
										CH_LF: begin
											cursor_x_q <= '0;
											cursor_y_q <= y_plus_h;
										end
										CH_CR: cursor_x_q <= '0;
										CH_VT: cursor_y_q <= y_plus_h;
										CH_BS: begin
											cursor_x_q <= bs_x;
											cursor_y_q <= bs_y;
											row_q      <= '0;
											glyphs_left_q <= '0;
											clear_q    <= 1'b1;
											state_q    <= ST_EMIT;
										end
										CH_TAB: begin
											code_q        <= CH_SPACE;
											row_q         <= '0;
											glyphs_left_q <= TW'(TAB_SPACES - 1);
											clear_q       <= 1'b0;
											state_q       <= ST_EMIT;
										end
										default: begin
											code_q        <= byte_value;
											row_q         <= '0;
											glyphs_left_q <= '0;
											clear_q       <= 1'b0;
											state_q       <= ST_EMIT;
										end
									endcase
								end
							end
							ACT_CELL: begin
								if (enabled_q) begin
									cursor_x_q <= {cell_col, 3'b000};
									cursor_y_q <= cell_y;
								end
							end
							ACT_PIXEL: begin
								cursor_x_q <= pixel_x;
								cursor_y_q <= pixel_y;
							end
							ACT_FONT: ;
							default: ;
						endcase
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						// one beat per glyph row
						out_valid_q   <= 1'b1;
						row_x_q       <= cursor_x_q;
						row_y_q       <= y_row;
						row_mask_q    <= clear_q ? 8'hff : rd_data_q;
						pixel_color_q <= clear_q ? clear_color_q : fg_color_q;
						last_q        <= row_last && (glyphs_left_q == '0);
						if (!row_last) begin
							row_q <= row_q + RW'(1);
						end else begin
							row_q <= '0;
							if (!clear_q) begin
								cursor_x_q <= adv_x;
								cursor_y_q <= adv_y;
							end
							if (glyphs_left_q != '0) begin
								glyphs_left_q <= glyphs_left_q - TW'(1);
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign row_x       = row_x_q;
	assign row_y       = row_y_q;
	assign row_mask    = row_mask_q;
	assign pixel_color = pixel_color_q;
	assign last        = last_q;

endmodule

// ===== hdl/tcgr_checker.sv =====
module tcgr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_write,
	input logic [2:0]  cfg_index,
	input logic [31:0] cfg_data,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  action,
	input logic [7:0]  byte_value,
	input logic [12:0] cell_col,
	input logic [11:0] cell_row,
	input logic [15:0] pixel_x,
	input logic [15:0] pixel_y,
	input logic [7:0]  glyph_code,
	input logic [3:0]  glyph_row,
	input logic [7:0]  glyph_bits,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] row_x,
	input logic [15:0] row_y,
	input logic [7:0]  row_mask,
	input logic [31:0] pixel_color,
	input logic        last
);
	import tcgr_pkg::*;

	// a pending beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(row_x) && $stable(row_y) &&
		$stable(row_mask) && $stable(pixel_color) && $stable(last))
		else $error("result payload changed while stalled");

	// while a beat that is not the last is offered, more rows follow and no item is taken
	a_busy_mid_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input taken while rows are still pending");

	// a pixel move finishes in its own cycle
	a_pixel_move_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_PIXEL |=> in_ready)
		else $error("pixel move left the block busy");

	// the block is idle again after a font load
	a_font_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_FONT |=> in_ready)
		else $error("font load left the block busy");

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (.*);

// ===== tb/sv/text_console_glyph_renderer_checker.sv =====
module text_console_glyph_renderer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  byte_value,
	input  logic [12:0] cell_col,
	input  logic [11:0] cell_row,
	input  logic [15:0] pixel_x,
	input  logic [15:0] pixel_y,
	input  logic [7:0]  glyph_code,
	input  logic [3:0]  glyph_row,
	input  logic [7:0]  glyph_bits,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] row_x,
	input  logic [15:0] row_y,
	input  logic [7:0]  row_mask,
	input  logic [31:0] pixel_color,
	input  logic        last,
	output int          failures,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tcgr_pkg::*;

	// one expected row span
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  mask;
		logic [31:0] color;
		logic        last;
	} span_t;

	span_t       rows_due [$];
	span_t       due;
	int          errs;
	int          before_cnt;

	// shadow registers and cursor
	logic [31:0] fg_col;
	logic [31:0] clr_col;
	logic [12:0] scr_w;
	logic [4:0]  gh_reg;
	logic        en;
	int unsigned cur_x;
	int unsigned cur_y;
	logic [7:0]  font_rows [GLYPH_COUNT * MAX_GLYPH_ROWS_DEF];

	function automatic int unsigned rows_per_glyph();
		if (gh_reg == 0)
			return 1;
		if (gh_reg > MAX_GLYPH_ROWS_DEF)
			return MAX_GLYPH_ROWS_DEF;
		return gh_reg;
	endfunction

	function automatic int unsigned clamp16(int unsigned v);
		return (v > 65535) ? 65535 : v;
	endfunction

	function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
		if (want === got)
			return 0;
		$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
		return 1;
	endfunction

	task automatic put_row(int unsigned x, int unsigned y, logic [7:0] m, logic [31:0] c);
		span_t s;
		s.x     = 16'(x);
		s.y     = 16'(y);
		s.mask  = m;
		s.color = c;
		s.last  = 1'b0;
		rows_due.push_back(s);
	endtask

	// one glyph at the cursor, then advance with wrap
	task automatic stamp_glyph(logic [7:0] code);
		int unsigned h;
		h = rows_per_glyph();
		for (int unsigned r = 0; r < h; r++)
			put_row(cur_x, clamp16(cur_y + r), font_rows[code * MAX_GLYPH_ROWS_DEF + r],
				fg_col);
		if (cur_x + 2 * GLYPH_WIDTH > scr_w) begin
			cur_x = 0;
			cur_y = clamp16(cur_y + h);
		end else begin
			cur_x = cur_x + GLYPH_WIDTH;
		end
	endtask

	// step back one cell, wrapping to the line above, and clear it
	task automatic rub_out();
		int unsigned h;
		h = rows_per_glyph();
		if (cur_x != 0 || cur_y != 0) begin
			if (cur_x == 0) begin
				cur_x = scr_w;
				cur_y = (cur_y > h) ? cur_y - h : 0;
			end
			cur_x = (cur_x >= GLYPH_WIDTH) ? cur_x - GLYPH_WIDTH : 0;
		end
		for (int unsigned r = 0; r < h; r++)
			put_row(cur_x, clamp16(cur_y + r), 8'hff, clr_col);
	endtask

	// expected rows for one accepted input beat
	task automatic predict_beat();
		span_t tail;
		before_cnt = rows_due.size();
		case (action_t'(action))
			ACT_TEXT: begin
				if (en) begin
					case (byte_value)
						CH_NUL: ;
						CH_LF: begin
							cur_y = clamp16(cur_y + rows_per_glyph());
							cur_x = 0;
						end
						CH_CR: cur_x = 0;
						CH_VT: cur_y = clamp16(cur_y + rows_per_glyph());
						CH_TAB: repeat (TAB_SPACES_DEF) stamp_glyph(CH_SPACE);
						CH_BS: rub_out();
						default: stamp_glyph(byte_value);
					endcase
				end
			end
			ACT_CELL: begin
				if (en) begin
					cur_x = clamp16(GLYPH_WIDTH * cell_col);
					cur_y = clamp16(cell_row * rows_per_glyph());
				end
			end
			ACT_PIXEL: begin
				cur_x = pixel_x;
				cur_y = pixel_y;
			end
			default: font_rows[glyph_code * MAX_GLYPH_ROWS_DEF + glyph_row] = glyph_bits;
		endcase
		// flag the final row of this beat
		if (rows_due.size() > before_cnt) begin
			tail = rows_due.pop_back();
			tail.last = 1'b1;
			rows_due.push_back(tail);
		end
	endtask

	// watch config, result and input beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_col   = FG_COLOR_RST;
			clr_col  = CLEAR_COLOR_RST;
			scr_w    = SCREEN_WIDTH_RST;
			gh_reg   = GLYPH_HEIGHT_RST;
			en       = 1'b0;
			cur_x    = 0;
			cur_y    = 0;
			errs     = 0;
			rows_due.delete();
			failures <= 0;
			pending  <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_FG_COLOR:     fg_col = cfg_data;
					REG_CLEAR_COLOR:  clr_col = cfg_data;
					REG_SCREEN_WIDTH: scr_w = cfg_data[12:0];
					REG_GLYPH_HEIGHT: gh_reg = cfg_data[4:0];
					REG_ENABLED:      en = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (rows_due.size() == 0) begin
					$error("row beat with nothing expected: x=%0d y=%0d", row_x, row_y);
					errs++;
				end else begin
					due = rows_due.pop_front();
					errs += field_bad("row_x", due.x, row_x);
					errs += field_bad("row_y", due.y, row_y);
					errs += field_bad("row_mask", due.mask, row_mask);
					errs += field_bad("pixel_color", due.color, pixel_color);
					errs += field_bad("last", due.last, last);
				end
			end
			if (in_valid && in_ready)
				predict_beat();
			failures <= errs;
			pending  <= rows_due.size();
		end
	end

endmodule

// ===== tb/sv/text_console_glyph_renderer_tb.sv =====
module text_console_glyph_renderer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcgr_pkg::*;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 400;
	localparam logic [7:0] FAVOURITES [6] = '{8'h41, 8'h61, 8'h23, CH_SPACE, 8'h7f, 8'h80};
	localparam logic [7:0] CONTROLS [6] = '{CH_BS, CH_TAB, CH_LF, CH_CR, CH_VT, CH_NUL};

	typedef struct {
		action_t     act;
		logic [7:0]  ch;
		logic [12:0] col;
		logic [11:0] crow;
		logic [15:0] px;
		logic [15:0] py;
		logic [7:0]  code;
		logic [3:0]  grow;
		logic [7:0]  bits;
	} console_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = '0;
	logic [7:0]  byte_value = '0;
	logic [12:0] cell_col = '0;
	logic [11:0] cell_row = '0;
	logic [15:0] pixel_x = '0;
	logic [15:0] pixel_y = '0;
	logic [7:0]  glyph_code = '0;
	logic [3:0]  glyph_row = '0;
	logic [7:0]  glyph_bits = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] row_x;
	logic [15:0] row_y;
	logic [7:0]  row_mask;
	logic [31:0] pixel_color;
	logic        last;
	int          failures;
	int          pending;

	// stimulus-side view of the block
	int          send_idle = 27;
	int          recv_idle = 49;
	int          hold_asks = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          cycles = 0;
	logic [4:0]  height_now = GLYPH_HEIGHT_RST;
	bit          en_now = 1'b0;
	logic [15:0] font_ready [GLYPH_COUNT];

	text_console_glyph_renderer dut (.*);

	text_console_glyph_renderer_checker checker_i (.*);

	// clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("text_console_glyph_renderer_tb: errors");
			$finish;
		end
	end

	// result side: random stalls plus the long hold-off
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	function automatic int glyph_rows();
		if (height_now == 0)
			return 1;
		if (height_now > MAX_GLYPH_ROWS_DEF)
			return MAX_GLYPH_ROWS_DEF;
		return height_now;
	endfunction

	function automatic console_cmd_t noise_cmd();
		console_cmd_t c;
		c.act  = action_t'($urandom_range(0, 3));
		c.ch   = 8'($urandom);
		c.col  = 13'($urandom);
		c.crow = 12'($urandom);
		c.px   = 16'($urandom);
		c.py   = 16'($urandom);
		c.code = 8'($urandom);
		c.grow = 4'($urandom);
		c.bits = 8'($urandom);
		return c;
	endfunction

	// a beat with the fields of its action set and the rest random
	function automatic console_cmd_t cmd_of(action_t a, int p, int q, int s);
		console_cmd_t c;
		c = noise_cmd();
		c.act = a;
		case (a)
			ACT_TEXT: c.ch = 8'(p);
			ACT_CELL: begin
				c.col  = 13'(p);
				c.crow = 12'(q);
			end
			ACT_PIXEL: begin
				c.px = 16'(p);
				c.py = 16'(q);
			end
			default: begin
				c.code = 8'(p);
				c.grow = 4'(q);
				c.bits = 8'(s);
			end
		endcase
		return c;
	endfunction

	// hold the beat on the input until it is taken
	task automatic offer(console_cmd_t c);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= c.act;
		byte_value <= c.ch;
		cell_col   <= c.col;
		cell_row   <= c.crow;
		pixel_x    <= c.px;
		pixel_y    <= c.py;
		glyph_code <= c.code;
		glyph_row  <= c.grow;
		glyph_bits <= c.bits;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// load any glyph rows still missing at the current height
	task automatic ensure_glyph(logic [7:0] code);
		console_cmd_t f;
		for (int r = 0; r < glyph_rows(); r++) begin
			if (!font_ready[code][r]) begin
				f = cmd_of(ACT_FONT, code, r, $urandom_range(0, 255));
				offer(f);
				font_ready[code][r] = 1'b1;
			end
		end
	endtask

	task automatic issue(console_cmd_t c);
		if (c.act == ACT_TEXT && en_now) begin
			if (c.ch == CH_TAB)
				ensure_glyph(CH_SPACE);
			else if (!(c.ch inside {CH_NUL, CH_BS, CH_LF, CH_VT, CH_CR}))
				ensure_glyph(c.ch);
		end
		offer(c);
		if (c.act == ACT_FONT)
			font_ready[c.code][c.grow] = 1'b1;
	endtask

	// let every expected row out, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_GLYPH_HEIGHT: height_now = val[4:0];
			REG_ENABLED:      en_now = val[0];
			default: ;
		endcase
	endtask

	initial begin
		int          n;
		int          kind;
		logic [31:0] fg_v;
		logic [31:0] clr_v;
		logic [12:0] w_v;
		logic [4:0]  h_v;
		bit          en_v;
		logic [7:0]  code;

		foreach (font_ready[i])
			font_ready[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled: text and cell beats do nothing, pixel and font beats still act
		issue(cmd_of(ACT_TEXT, 8'h41, 0, 0));
		issue(cmd_of(ACT_CELL, 8191, 4095, 0));
		issue(cmd_of(ACT_FONT, 8'hff, 15, 8'hff));
		issue(cmd_of(ACT_PIXEL, 65535, 65535, 0));
		drain();
		write_reg(REG_FG_COLOR, 32'h8000_0001);
		write_reg(REG_CLEAR_COLOR, 32'h7fff_fffe);
		write_reg(REG_SCREEN_WIDTH, 32'd8);
		write_reg(REG_GLYPH_HEIGHT, 32'd3);
		write_reg(REG_ENABLED, 32'd1);

		// empty glyph row, drawn at the saturated corner
		issue(cmd_of(ACT_FONT, 8'h41, 1, 8'h00));
		issue(cmd_of(ACT_TEXT, 8'h41, 0, 0));
		// cell move to the largest column and row
		issue(cmd_of(ACT_CELL, 8191, 4095, 0));
		issue(cmd_of(ACT_TEXT, 8'hff, 0, 0));
		// backspace at origin, at line start, and below x zero
		issue(cmd_of(ACT_PIXEL, 0, 0, 0));
		issue(cmd_of(ACT_TEXT, CH_BS, 0, 0));
		issue(cmd_of(ACT_PIXEL, 0, 1, 0));
		issue(cmd_of(ACT_TEXT, CH_BS, 0, 0));
		issue(cmd_of(ACT_PIXEL, 3, 20, 0));
		issue(cmd_of(ACT_TEXT, CH_BS, 0, 0));
		// control bytes and a drawn control code
		issue(cmd_of(ACT_TEXT, CH_NUL, 0, 0));
		issue(cmd_of(ACT_TEXT, CH_TAB, 0, 0));
		issue(cmd_of(ACT_TEXT, CH_LF, 0, 0));
		issue(cmd_of(ACT_TEXT, CH_CR, 0, 0));
		issue(cmd_of(ACT_TEXT, CH_VT, 0, 0));
		issue(cmd_of(ACT_TEXT, 8'h01, 0, 0));
		// y saturation on newline and on glyph rows
		issue(cmd_of(ACT_PIXEL, 0, 65534, 0));
		issue(cmd_of(ACT_TEXT, CH_LF, 0, 0));
		issue(cmd_of(ACT_TEXT, 8'h41, 0, 0));

		// random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			send_idle = (ph < 2) ? 27 : (ph < 4) ? 49 : 0;
			recv_idle = (ph < 2) ? 49 : (ph < 4) ? 27 : 0;
			fg_v  = $urandom;
			clr_v = $urandom;
			case (ph)
				0: begin w_v = 13'd640;  h_v = 5'd16; en_v = 1'b1; end
				1: begin
					w_v = 13'd8191; h_v = 5'd0; en_v = 1'b1;
					fg_v = 32'hffff_ffff; clr_v = 32'h0;
				end
				2: begin w_v = 13'd9;    h_v = 5'd31; en_v = 1'b1; end
				3: begin w_v = 13'd4096; h_v = 5'd7;  en_v = 1'b0; end
				4: begin
					w_v = 13'd0; h_v = 5'd1; en_v = 1'b1;
					fg_v = 32'h0; clr_v = 32'hffff_ffff;
				end
				default: begin
					w_v  = 13'($urandom_range(100, 500));
					h_v  = 5'($urandom_range(1, 16));
					en_v = 1'b1;
				end
			endcase
			write_reg(REG_FG_COLOR, fg_v);
			write_reg(REG_CLEAR_COLOR, clr_v);
			// junk above each register's width
			write_reg(REG_SCREEN_WIDTH, (32'($urandom) & ~32'h1fff) | w_v);
			write_reg(REG_GLYPH_HEIGHT, (32'($urandom) & ~32'h1f) | h_v);
			write_reg(REG_ENABLED, (32'($urandom) & ~32'h1) | en_v);
			if (ph == 2)
				hold_asks++;

			// font rows loaded on demand add to these beats
			n = (ph == 3) ? 20 : 40;
			repeat (n) begin
				kind = $urandom_range(0, 99);
				if (kind < 50) begin
					code = ($urandom_range(0, 9) == 0) ? 8'($urandom)
						: FAVOURITES[$urandom_range(0, 5)];
					issue(cmd_of(ACT_TEXT, code, 0, 0));
				end else if (kind < 62) begin
					issue(cmd_of(ACT_TEXT, CONTROLS[$urandom_range(0, 5)], 0, 0));
				end else if (kind < 72) begin
					if ($urandom_range(0, 5) == 0)
						issue(cmd_of(ACT_PIXEL, $urandom_range(0, 65535),
							$urandom_range(0, 65535), 0));
					else
						issue(cmd_of(ACT_PIXEL, $urandom_range(0, 700),
							$urandom_range(0, 600), 0));
				end else if (kind < 80) begin
					if ($urandom_range(0, 5) == 0)
						issue(cmd_of(ACT_CELL, $urandom_range(0, 8191),
							$urandom_range(0, 4095), 0));
					else
						issue(cmd_of(ACT_CELL, $urandom_range(0, 80),
							$urandom_range(0, 40), 0));
				end else if (kind < 92) begin
					code = ($urandom_range(0, 3) == 0) ? 8'($urandom)
						: FAVOURITES[$urandom_range(0, 5)];
					issue(cmd_of(ACT_FONT, code, $urandom_range(0, 15),
						$urandom_range(0, 255)));
				end else begin
					issue(noise_cmd());
				end
			end
		end

		drain();
		if (failures == 0 && pending == 0)
			$display("text_console_glyph_renderer_tb: clean");
		else
			$display("text_console_glyph_renderer_tb: errors");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tcgr_pkg.sv
hdl/text_console_glyph_renderer.sv
hdl/tcgr_checker.sv
tb/sv/text_console_glyph_renderer_checker.sv
tb/sv/text_console_glyph_renderer_tb.sv
